FILE: rtl/tcfe_pkg.sv
// Shared types, constants and lookup functions for the tube clock frame encoder.
package tcfe_pkg;

  localparam int TIME_W          = 20;
  localparam int BYTE_W          = 8;
  localparam int DIGIT_W         = 4;
  localparam int DIGIT_COUNT_DEF = 6;
  localparam int BCD_NDIG        = 8;
  localparam int BCD_W           = BCD_NDIG * DIGIT_W;
  localparam int CONV_BITS       = 2;
  localparam int CONV_STEPS      = TIME_W / CONV_BITS;
  localparam int CONV_CNT_W      = $clog2(CONV_STEPS);
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [BYTE_W-1:0] STATUS_DOTS = 8'b0010_0000;
  localparam int STATUS_ALARM_BIT = 1;
  localparam int STATUS_SYNC_BIT  = 3;

  typedef enum logic [1:0] {
    FRONT_IDLE,
    FRONT_CONV,
    FRONT_HOLD
  } front_state_t;

  typedef struct packed {
    logic oversize;
    logic alarm;
    logic sync;
  } tcfe_flags_t;

  localparam int FLAGS_W = $bits(tcfe_flags_t);

  function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] bcd,
                                                   input logic             bin_bit);
    logic [BCD_W-1:0] adj;
    adj = bcd;
    for (int i = 0; i < BCD_NDIG; i++) begin
      if (adj[DIGIT_W*i +: DIGIT_W] >= 4'd5) begin
        adj[DIGIT_W*i +: DIGIT_W] = adj[DIGIT_W*i +: DIGIT_W] + 4'd3;
      end
    end
    return {adj[BCD_W-2:0], bin_bit};
  endfunction

  function automatic logic [BYTE_W-1:0] wire_first(input logic [DIGIT_W-1:0] digit);
    logic [BYTE_W-1:0] b;
    case (digit)
      4'd0:    b = 8'b0000_0100;
      4'd1:    b = 8'b0000_0010;
      4'd4:    b = 8'b0010_0000;
      4'd5:    b = 8'b1000_0000;
      4'd9:    b = 8'b0001_0000;
      default: b = 8'b0000_0000;
    endcase
    return b;
  endfunction

  function automatic logic [BYTE_W-1:0] wire_second(input logic [DIGIT_W-1:0] digit);
    logic [BYTE_W-1:0] b;
    case (digit)
      4'd2:    b = 8'b1000_0000;
      4'd3:    b = 8'b0001_0000;
      4'd6:    b = 8'b0000_0010;
      4'd7:    b = 8'b0000_0100;
      4'd8:    b = 8'b0010_0000;
      default: b = 8'b0000_0000;
    endcase
    return b;
  endfunction

  function automatic logic [BYTE_W-1:0] status_byte(input logic alarm, input logic sync);
    logic [BYTE_W-1:0] b;
    b = STATUS_DOTS;
    b[STATUS_ALARM_BIT] = alarm;
    b[STATUS_SYNC_BIT]  = sync;
    return b;
  endfunction

endpackage

FILE: rtl/tcfe_in_if.sv
// Input request channel: time value and status flags.
interface tcfe_in_if
  import tcfe_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] time_value;
  logic              alarm_set;
  logic              synchronized;

  modport source (output valid, output time_value, output alarm_set, output synchronized,
                  input ready);
  modport sink   (input valid, input time_value, input alarm_set, input synchronized,
                  output ready);
endinterface

FILE: rtl/tcfe_out_if.sv
// Output request channel: one chain byte with its latch marker.
interface tcfe_out_if
  import tcfe_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] chain_byte;
  logic              latch_after;

  modport source (output valid, output chain_byte, output latch_after, input ready);
  modport sink   (input valid, input chain_byte, input latch_after, output ready);
endinterface

FILE: rtl/tcfe_front.sv
// Front end: accepts a request and converts the time value to BCD, two bits a cycle.
module tcfe_front
  import tcfe_pkg::*;
#(
  parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  tcfe_in_if.sink                               in_req,
  output logic                                  push_valid,
  input  logic                                  push_ready,
  output logic [DIGIT_COUNT-1:0][DIGIT_W-1:0]   push_digits,
  output tcfe_flags_t                           push_flags
);

  front_state_t          state_r, state_nxt;
  logic [TIME_W-1:0]     bin_r;
  logic [BCD_W-1:0]      bcd_r;
  logic [CONV_CNT_W-1:0] cnt_r;
  logic                  alarm_r;
  logic                  sync_r;
  logic                  accept;
  logic                  last_step;
  logic                  oversize;
  logic [BCD_W-1:0]      bcd_step;

  assign accept    = in_req.valid && in_req.ready;
  assign last_step = cnt_r == CONV_CNT_W'(CONV_STEPS - 1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FRONT_IDLE: if (accept) state_nxt = FRONT_CONV;
      FRONT_CONV: if (last_step) state_nxt = FRONT_HOLD;
      FRONT_HOLD: if (push_ready) state_nxt = FRONT_IDLE;
      default:    state_nxt = FRONT_IDLE;
    endcase
  end

  always_comb begin
    in_req.ready = 1'b0;
    push_valid   = 1'b0;
    case (state_r)
      FRONT_IDLE: in_req.ready = 1'b1;
      FRONT_HOLD: push_valid   = 1'b1;
      default: begin
        in_req.ready = 1'b0;
        push_valid   = 1'b0;
      end
    endcase
  end

  always_comb begin
    bcd_step = bcd_r;
    for (int k = 0; k < CONV_BITS; k++) begin
      bcd_step = dabble_step(bcd_step, bin_r[TIME_W-1-k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FRONT_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bin_r   <= in_req.time_value;
      bcd_r   <= '0;
      cnt_r   <= '0;
      alarm_r <= in_req.alarm_set;
      sync_r  <= in_req.synchronized;
    end else if (state_r == FRONT_CONV) begin
      bin_r <= bin_r << CONV_BITS;
      bcd_r <= bcd_step;
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_comb begin
    oversize = 1'b0;
    for (int i = DIGIT_COUNT; i < BCD_NDIG; i++) begin
      oversize = oversize | (|bcd_r[DIGIT_W*i +: DIGIT_W]);
    end
  end

  always_comb begin
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      push_digits[i] = bcd_r[DIGIT_W*i +: DIGIT_W];
    end
  end

  assign push_flags.oversize = oversize;
  assign push_flags.alarm    = alarm_r;
  assign push_flags.sync     = sync_r;

endmodule

FILE: rtl/tcfe_queue.sv
// Two-entry queue between the converter and the byte sequencer.
module tcfe_queue
  import tcfe_pkg::*;
#(
  parameter int DATA_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  logic [DATA_W-1:0] push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output logic [DATA_W-1:0] pop_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_W-1:0] mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign push_ready = cnt_r != CNT_W'(QUEUE_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    if (!do_push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/tcfe_back.sv
// Back end: walks the digit bytes and status byte of the head entry into the output register.
module tcfe_back
  import tcfe_pkg::*;
#(
  parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                pop_valid,
  output logic                                pop_ready,
  input  logic [DIGIT_COUNT-1:0][DIGIT_W-1:0] pop_digits,
  input  tcfe_flags_t                         pop_flags,
  tcfe_out_if.source                          out_req
);

  localparam int SLOTS  = 2 * DIGIT_COUNT + 1;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int DIG_IW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

  logic [SLOT_W-1:0]                    slot_r, slot_nxt;
  logic [SLOT_W-1:0]                    eff;
  logic [SLOT_W-1:0]                    pos;
  logic [(1<<DIG_IW)-1:0][DIGIT_W-1:0]  dig_pad;
  logic [DIGIT_W-1:0]                   dig;
  logic                                 is_status;
  logic                                 load;
  logic [BYTE_W-1:0]                    byte_sel;
  logic                                 out_valid_r;
  logic [BYTE_W-1:0]                    chain_byte_r;
  logic                                 latch_after_r;

  always_comb begin
    dig_pad                  = '0;
    dig_pad[DIGIT_COUNT-1:0] = pop_digits;
  end

  // skip the leading digit's pair when it is out of range
  assign eff       = (slot_r == '0 && pop_flags.oversize) ? SLOT_W'(2) : slot_r;
  assign is_status = eff == SLOT_W'(SLOTS - 1);
  assign pos       = SLOT_W'(DIGIT_COUNT - 1) - (eff >> 1);
  assign dig       = dig_pad[pos[DIG_IW-1:0]];

  always_comb begin
    if (is_status) begin
      byte_sel = status_byte(pop_flags.alarm, pop_flags.sync);
    end else if (eff[0]) begin
      byte_sel = wire_second(dig);
    end else begin
      byte_sel = wire_first(dig);
    end
  end

  assign load      = pop_valid && (!out_valid_r || out_req.ready);
  assign pop_ready = load && is_status;

  always_comb begin
    slot_nxt = slot_r;
    if (load) slot_nxt = is_status ? '0 : eff + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      slot_r <= slot_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_req.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      chain_byte_r  <= byte_sel;
      latch_after_r <= is_status;
    end
  end

  assign out_req.valid       = out_valid_r;
  assign out_req.chain_byte  = chain_byte_r;
  assign out_req.latch_after = latch_after_r;

endmodule

FILE: rtl/tube_clock_frame_encoder_unit.sv
// Top level of the tube clock frame encoder: converter, queue and byte sequencer.
//
//   port      dir  payload                                   handshake
//   in_req    in   time_value[19:0], alarm_set, synchronized  valid/ready
//   out_req   out  chain_byte[7:0], latch_after               valid/ready
//
// The front converts a value in order: accept, 10 two-bit BCD steps, hand-off.
// The back sends 2*DIGIT_COUNT+1 bytes a request at one a cycle while the output is ready,
// 2*DIGIT_COUNT-1 when the leading digit exceeds 9; the slower of front and back sets the rate.
// Reset is synchronous, active low, and empties the queue and output register.
// A stalled output holds its byte; the two-entry queue lets the front keep converting.
module tube_clock_frame_encoder_unit
  import tcfe_pkg::*;
#(
  parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  tcfe_in_if.sink     in_req,
  tcfe_out_if.source  out_req
);

  localparam int Q_W = DIGIT_COUNT * DIGIT_W + FLAGS_W;

  logic                                push_valid, push_ready;
  logic [DIGIT_COUNT-1:0][DIGIT_W-1:0] push_digits;
  tcfe_flags_t                         push_flags;
  logic                                pop_valid, pop_ready;
  logic [Q_W-1:0]                      pop_data;
  logic [DIGIT_COUNT-1:0][DIGIT_W-1:0] pop_digits;
  tcfe_flags_t                         pop_flags;

  tcfe_front #(.DIGIT_COUNT(DIGIT_COUNT)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_req      (in_req),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_digits (push_digits),
    .push_flags  (push_flags)
  );

  tcfe_queue #(.DATA_W(Q_W)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_flags, push_digits}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  assign pop_digits = pop_data[DIGIT_COUNT*DIGIT_W-1:0];
  assign pop_flags  = tcfe_flags_t'(pop_data[Q_W-1 -: FLAGS_W]);

  tcfe_back #(.DIGIT_COUNT(DIGIT_COUNT)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_digits (pop_digits),
    .pop_flags  (pop_flags),
    .out_req    (out_req)
  );

  a_status_dots: assert property (@(posedge clk) disable iff (!rst_n)
    out_req.valid && out_req.latch_after |-> out_req.chain_byte[5])
    else $error("status byte without dots bit");

  a_digit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_req.valid && !out_req.latch_after |-> $onehot0(out_req.chain_byte))
    else $error("digit byte drives more than one segment");

  a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_req.valid && in_req.ready |=> !in_req.ready)
    else $error("front accepted a request while converting");

  a_pop_on_status: assert property (@(posedge clk) disable iff (!rst_n)
    pop_ready |=> out_req.valid && out_req.latch_after)
    else $error("queue entry released without a status byte");

endmodule

FILE: bench/tb_top.sv
// Testbench for the tube clock frame encoder: directed and random requests, byte-stream checks.
`timescale 1ns / 100ps

module tb_top;
  import tcfe_pkg::*;

  localparam int REQ_TARGET   = 180;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [BYTE_W-1:0] chain_byte;
    logic              latch_after;
  } chain_beat_t;

  class chain_byte_tracker;
    chain_beat_t       pending_bytes[$];
    int                errors;
    logic [BYTE_W-1:0] first_drive[10];
    logic [BYTE_W-1:0] second_drive[10];

    function new();
      errors       = 0;
      first_drive  = '{8'h04, 8'h02, 8'h00, 8'h00, 8'h20, 8'h80, 8'h00, 8'h00, 8'h00, 8'h10};
      second_drive = '{8'h00, 8'h00, 8'h80, 8'h10, 8'h00, 8'h00, 8'h02, 8'h04, 8'h20, 8'h00};
    endfunction

    task flag_mismatch(string msg);
      $display("ERROR %0t: %s", $time, msg);
      errors++;
    endtask

    function void push_beat(logic [BYTE_W-1:0] b, logic l);
      chain_beat_t beat;
      beat.chain_byte  = b;
      beat.latch_after = l;
      pending_bytes.push_back(beat);
    endfunction

    function void note_request(logic [TIME_W-1:0] t, logic alarm, logic sync);
      int unsigned       rest;
      int unsigned       scale;
      int unsigned       digit;
      logic [BYTE_W-1:0] status;
      rest  = t;
      scale = 1;
      for (int i = 1; i < DIGIT_COUNT_DEF; i++) scale *= 10;
      while (scale > 0) begin
        digit = rest / scale;
        rest  = rest % scale;
        if (digit <= 9) begin
          push_beat(first_drive[digit], 1'b0);
          push_beat(second_drive[digit], 1'b0);
        end
        scale /= 10;
      end
      status = STATUS_DOTS;
      status[STATUS_ALARM_BIT] = alarm;
      status[STATUS_SYNC_BIT]  = sync;
      push_beat(status, 1'b1);
    endfunction

    task check_byte(logic [BYTE_W-1:0] b, logic l);
      chain_beat_t want;
      if (pending_bytes.size() == 0) begin
        flag_mismatch($sformatf("unexpected byte %02h latch %0b", b, l));
      end else begin
        want = pending_bytes.pop_front();
        if (b !== want.chain_byte)
          flag_mismatch($sformatf("chain_byte %02h, expected %02h", b, want.chain_byte));
        if (l !== want.latch_after)
          flag_mismatch($sformatf("latch_after %0b, expected %0b", l, want.latch_after));
      end
    endtask

    function int outstanding();
      return pending_bytes.size();
    endfunction

    task final_check();
      if (pending_bytes.size() != 0)
        flag_mismatch($sformatf("%0d bytes never arrived", pending_bytes.size()));
    endtask
  endclass

  logic clk;
  logic rst_n;

  tcfe_in_if  in_req ();
  tcfe_out_if out_req ();

  tube_clock_frame_encoder_unit uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_req (out_req)
  );

  chain_byte_tracker tracker = new();
  int                requests_sent;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL tube_clock_frame_encoder_unit");
    $finish;
  end

  task automatic offer_request(input logic [TIME_W-1:0] t, input logic a, input logic s);
    in_req.valid        <= 1'b1;
    in_req.time_value   <= t;
    in_req.alarm_set    <= a;
    in_req.synchronized <= s;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    tracker.note_request(t, a, s);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic idle_sender(input int cycles);
    in_req.valid        <= 1'b0;
    in_req.time_value   <= TIME_W'($urandom);
    in_req.alarm_set    <= 1'($urandom);
    in_req.synchronized <= 1'($urandom);
    repeat (cycles) @(negedge clk);
  endtask

  function automatic logic [TIME_W-1:0] pick_time();
    int unsigned kind;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2, 3: begin
        return TIME_W'($urandom_range(0, 23) * 10000 + $urandom_range(0, 59) * 100
                       + $urandom_range(0, 59));
      end
      4, 5: return TIME_W'($urandom_range(0, 999999));
      6, 7: return TIME_W'($urandom_range(1000000, 1048575));
      default: return TIME_W'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_req.valid && out_req.ready)
      tracker.check_byte(out_req.chain_byte, out_req.latch_after);
  end

  initial begin
    int unsigned mode;
    int unsigned span;
    int          stall_count;
    out_req.ready = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    for (stall_count = 0; stall_count < 150; stall_count++) @(negedge clk);
    forever begin
      mode = $urandom_range(0, 4);
      span = $urandom_range(10, 60);
      repeat (span) begin
        case (mode)
          0:       out_req.ready <= 1'b1;
          1:       out_req.ready <= 1'($urandom);
          2:       out_req.ready <= ($urandom_range(0, 3) == 0);
          3:       out_req.ready <= ($urandom_range(0, 7) != 0);
          default: out_req.ready <= 1'b0;
        endcase
        @(negedge clk);
      end
    end
  end

  initial begin
    logic [TIME_W-1:0] directed_times[$];
    int unsigned       burst;
    rst_n               = 1'b0;
    in_req.valid        = 1'b0;
    in_req.time_value   = '0;
    in_req.alarm_set    = 1'b0;
    in_req.synchronized = 1'b0;
    requests_sent       = 0;
    directed_times = '{20'd0, 20'd999999, 20'd1000000, 20'd1048575, 20'd123456,
                       20'd789012, 20'd345678, 20'd901234, 20'd235959, 20'd100000,
                       20'd99999, 20'd9, 20'd10, 20'd1000001, 20'd1000099,
                       20'd555555, 20'd888888};
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_times[i])
      offer_request(directed_times[i], i[0], i[1]);
    offer_request(20'd120000, 1'b1, 1'b1);
    offer_request(20'd120000, 1'b0, 1'b0);

    while (requests_sent < REQ_TARGET) begin
      burst = $urandom_range(1, 10);
      repeat (burst) offer_request(pick_time(), 1'($urandom), 1'($urandom));
      if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 16));
    end
    idle_sender(1);

    while (tracker.outstanding() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    tracker.final_check();
    if (tracker.errors == 0) begin
      $display("PASS tube_clock_frame_encoder_unit");
    end else begin
      $display("FAIL tube_clock_frame_encoder_unit");
    end
    $finish;
  end

endmodule
